// File: src/ssi_pkg.sv
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int SAMPLE_W   = 16;
    localparam int H_W        = 24;
    localparam int SUM_W      = 38;
    localparam int S_W        = SUM_W + 1;
    localparam int C_W        = 20;
    localparam int T_W        = S_W + 3;
    localparam int INTEGRAL_W = 58;
    localparam int STATUS_W   = 2;

    localparam logic [H_W-1:0] STEP_SIZE_RESET = 24'd65536;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

    // divide-by-three constants: (2^20 - 1) / 3 and ceil(2^k / 3) for k = 22, 27
    localparam logic [18:0] THIRD_OF_2P20 = 19'd349525;
    localparam logic [20:0] RECIP3_K22    = 21'd1398102;
    localparam logic [25:0] RECIP3_K27    = 26'd44739243;

    typedef struct packed {
        logic signed [S_W-1:0]  s;
        logic signed [C_W-1:0]  c;
        logic [STATUS_W-1:0]    status;
    } run_end_t;

endpackage

// File: src/ssi_accum.sv
`timescale 1ns / 1ps

module ssi_accum import ssi_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                last,
    output run_end_t            term
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int WV_W  = SAMPLE_W + 2;

    logic signed [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SAMPLE_W-1:0] recent0_reg;
    logic signed [SAMPLE_W-1:0] recent1_reg;
    logic                       ovf_reg;

    logic signed [SAMPLE_BITS-1:0] v_low;
    logic signed [SAMPLE_W-1:0]    v;
    logic signed [WV_W-1:0]        v_ext;
    logic signed [WV_W-1:0]        wv;
    logic                          ovf;
    logic                          odd_idx;
    logic signed [S_W-1:0]         ws_e;
    logic signed [S_W-1:0]         v_s;
    logic signed [S_W-1:0]         r0_s;
    logic signed [C_W-1:0]         v_c;
    logic signed [C_W-1:0]         r0_c;
    logic signed [C_W-1:0]         r1_c;

    assign v_low   = sample[SAMPLE_BITS-1:0];
    assign v       = SAMPLE_W'(v_low);
    assign v_ext   = WV_W'(v);
    assign odd_idx = count_reg[0];
    assign ovf     = ovf_reg || (count_reg == CNT_W'(MAX_SAMPLES));

    // weights 1, 4, 2, 4, 2, ...
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            wv = v_ext;
        end
        else if (odd_idx)
        begin
            wv = v_ext <<< 2;
        end
        else
        begin
            wv = v_ext <<< 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            count_reg   <= '0;
            recent0_reg <= '0;
            recent1_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (beat)
        begin
            if (last)
            begin
                sum_reg     <= '0;
                count_reg   <= '0;
                recent0_reg <= '0;
                recent1_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else if (ovf)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                sum_reg     <= sum_reg + SUM_W'(wv);
                recent1_reg <= recent0_reg;
                recent0_reg <= v;
                count_reg   <= count_reg + CNT_W'(1);
            end
        end
    end

    assign ws_e = S_W'(sum_reg);
    assign v_s  = S_W'(v);
    assign r0_s = S_W'(recent0_reg);
    assign v_c  = C_W'(v);
    assign r0_c = C_W'(recent0_reg);
    assign r1_c = C_W'(recent1_reg);

    // terms for a run that ends on this beat; an odd count (an even number of samples) closes with the end interval
    always_comb
    begin
        priority if (ovf)
        begin
            term.status = STATUS_TOO_MANY;
        end
        else if (count_reg < CNT_W'(2))
        begin
            term.status = STATUS_TOO_FEW;
        end
        else
        begin
            term.status = STATUS_OK;
        end

        if (term.status != STATUS_OK)
        begin
            term.s = '0;
            term.c = '0;
        end
        else if (odd_idx)
        begin
            term.s = ws_e - r0_s;
            term.c = (r0_c <<< 3) + (v_c <<< 2) + v_c - r1_c;
        end
        else
        begin
            term.s = ws_e + v_s;
            term.c = '0;
        end
    end

endmodule

// File: src/ssi_scale.sv
`timescale 1ns / 1ps

module ssi_scale import ssi_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [H_W-1:0]               step_size,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  run_end_t                     in_term,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [INTEGRAL_W-1:0] integral,
    output logic [STATUS_W-1:0]          status
);

    localparam int NSTAGE = 6;
    localparam int X_W    = T_W - 2;
    localparam int SPLIT  = 20;
    localparam int A_W    = X_W - SPLIT;
    localparam int SUMX_W = SPLIT + 1;
    localparam int PS_W   = SUMX_W + 21;
    localparam int Q2_W   = PS_W - 22;
    localparam int AM_W   = A_W + 19;
    localparam int Q_W    = X_W - 1;
    localparam int QH_W   = Q_W - SPLIT;
    localparam int HQL_W  = H_W + SPLIT;
    localparam int HQH_W  = H_W + QH_W;
    localparam int HR_W   = H_W + 4;
    localparam int HR4_W  = HR_W - 2;
    localparam int FP_W   = HR4_W + 26;
    localparam int FR_W   = FP_W - 27;
    localparam int HQ_W   = H_W + Q_W;

    logic [NSTAGE-1:0]   stage_valid_reg;
    logic                out_valid_reg;
    logic [NSTAGE:0]     en;
    logic [STATUS_W-1:0] status_reg [NSTAGE];
    logic [NSTAGE-1:1]   neg_reg;

    // stage payloads
    logic signed [S_W-1:0] s0_reg;
    logic signed [C_W-1:0] c0_reg;
    logic [T_W-1:0]        mag1_reg;
    logic [Q2_W-1:0]       q2_2_reg;
    logic [AM_W-1:0]       am2_reg;
    logic [SUMX_W-1:0]     sumx2_reg;
    logic [1:0]            rem2_reg;
    logic [Q_W-1:0]        q3_reg;
    logic [3:0]            r3_reg;
    logic [HQL_W-1:0]      hql4_reg;
    logic [HQH_W-1:0]      hqh4_reg;
    logic [HR_W-1:0]       hr4_reg;
    logic [HQ_W-1:0]       hq5_reg;
    logic [FR_W-1:0]       frac5_reg;
    logic signed [INTEGRAL_W-1:0] integral_reg;
    logic [STATUS_W-1:0]   status_out_reg;

    logic signed [T_W-1:0] t1;
    logic [X_W-1:0]        x2;
    logic [SUMX_W-1:0]     sumx2;
    logic [PS_W-1:0]       ps2;
    logic [AM_W-1:0]       am2;
    logic [SUMX_W-1:0]     three_q3;
    logic [SUMX_W-1:0]     m_full3;
    logic [HQL_W-1:0]      hql4;
    logic [HQH_W-1:0]      hqh4;
    logic [HR_W-1:0]       hr4;
    logic [FP_W-1:0]       fp5;
    logic [HQ_W-1:0]       mag6;
    logic [HQ_W-1:0]       res6;

    // a stage loads when empty or when the one after it moves on
    always_comb
    begin
        en[NSTAGE] = !out_valid_reg || out_ready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            en[i] = !stage_valid_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = out_valid_reg;
    assign integral  = integral_reg;
    assign status    = status_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                stage_valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    stage_valid_reg[i] <= stage_valid_reg[i-1];
                end
            end
            if (en[NSTAGE])
            begin
                out_valid_reg <= stage_valid_reg[NSTAGE-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            status_reg[0] <= in_term.status;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (en[i])
            begin
                status_reg[i] <= status_reg[i-1];
            end
        end
    end

    // 4s + c and its magnitude
    assign t1 = (T_W'(s0_reg) <<< 2) + T_W'(c0_reg);

    // |t| = 12q + r: x = |t| / 4 split so that x / 3 = a * (2^20 - 1) / 3 + (a + b) / 3
    assign x2    = mag1_reg[T_W-1:2];
    assign sumx2 = SUMX_W'(x2[X_W-1:SPLIT]) + SUMX_W'(x2[SPLIT-1:0]);
    assign ps2   = sumx2 * RECIP3_K22;
    assign am2   = x2[X_W-1:SPLIT] * THIRD_OF_2P20;

    assign three_q3 = (SUMX_W'(q2_2_reg) << 1) + SUMX_W'(q2_2_reg);
    assign m_full3  = sumx2_reg - three_q3;

    // h*|t|/12 = h*q + (h*r)/12
    assign hql4 = step_size * q3_reg[SPLIT-1:0];
    assign hqh4 = step_size * q3_reg[Q_W-1:SPLIT];
    assign hr4  = step_size * r3_reg;

    assign fp5 = hr4_reg[HR_W-1:2] * RECIP3_K27;

    assign mag6 = hq5_reg + HQ_W'(frac5_reg);
    assign res6 = neg_reg[NSTAGE-1] ? (~mag6 + HQ_W'(1)) : mag6;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= in_term.s;
            c0_reg <= in_term.c;
        end
        if (en[1])
        begin
            mag1_reg   <= t1[T_W-1] ? T_W'(-t1) : T_W'(t1);
            neg_reg[1] <= t1[T_W-1];
        end
        for (int i = 2; i < NSTAGE; i++)
        begin
            if (en[i])
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
        if (en[2])
        begin
            q2_2_reg  <= ps2[PS_W-1:22];
            am2_reg   <= am2;
            sumx2_reg <= sumx2;
            rem2_reg  <= mag1_reg[1:0];
        end
        if (en[3])
        begin
            q3_reg <= Q_W'(am2_reg) + Q_W'(q2_2_reg);
            r3_reg <= {m_full3[1:0], rem2_reg};
        end
        if (en[4])
        begin
            hql4_reg <= hql4;
            hqh4_reg <= hqh4;
            hr4_reg  <= hr4;
        end
        if (en[5])
        begin
            hq5_reg   <= HQ_W'(hql4_reg) + (HQ_W'(hqh4_reg) << SPLIT);
            frac5_reg <= fp5[FP_W-1:27];
        end
        if (en[NSTAGE])
        begin
            integral_reg   <= res6[INTEGRAL_W-1:0];
            status_out_reg <= status_reg[NSTAGE-1];
        end
    end

endmodule

// File: src/simpson_stream_integrator_top.sv
`timescale 1ns / 1ps

// channel    dir   beat contents
// s_*        in    tdata[15:0] sample, tlast marks the final sample of a run
// m_*        out   tdata[57:0] integral (16 fraction bits), tuser[1:0] status
// cfg_*      in    cfg_wdata[23:0] step size h, written when cfg_wen is high
//
// one sample beat is taken every cycle while s_tready is high; non-final samples update the running sum at once
// the result of a run is registered through the scaling stages and then held in the output register
// the scaling pipeline (h times sum, divide by twelve) collapses bubbles, so s_tready
// only falls when all six stages and the output register hold results
// reset clears the running sum, count and pipeline, and sets h to 1.0

module simpson_stream_integrator_top import ssi_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [H_W-1:0]      cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,   // [57:0] integral, [63:58] zero
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    logic [H_W-1:0]               step_size_reg;
    logic                         accept;
    run_end_t                     term;
    logic signed [INTEGRAL_W-1:0] integral;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_SIZE_RESET;
        end
        else if (cfg_wen)
        begin
            step_size_reg <= cfg_wdata;
        end
    end

    assign accept = s_tvalid && s_tready;

    ssi_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .beat   (accept),
        .sample (s_tdata),
        .last   (s_tlast),
        .term   (term)
    );

    ssi_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_size (step_size_reg),
        .in_valid  (accept && s_tlast),
        .in_ready  (s_tready),
        .in_term   (term),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .integral  (integral),
        .status    (m_tuser)
    );

    assign m_tdata = {{(64 - INTEGRAL_W){1'b0}}, integral};

endmodule
